### rtl/travel_speed_profiler_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef TRAVEL_SPEED_PROFILER_MACROS_SVH
`define TRAVEL_SPEED_PROFILER_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define TSP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also runs through reset.
`define TSP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

### rtl/tsp_pkg.sv
// Shared types, constants and helpers of the travel speed profiler.
package tsp_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int CW = $clog2(DW + 2);
    localparam int AW = 5;
    localparam int IW = AW - 2;

    localparam logic [IW-1:0] REG_MAX_SPEED      = IW'(0);
    localparam logic [IW-1:0] REG_MAX_ACCEL      = IW'(1);
    localparam logic [IW-1:0] REG_POSITION_GAIN  = IW'(2);
    localparam logic [IW-1:0] REG_TERMINAL_SPEED = IW'(3);
    localparam logic [IW-1:0] REG_TICK_PERIOD    = IW'(4);

    localparam logic [DW-1:0] T0_LOOKAHEAD = DW'(((64'd1 << FB) + 64'd5) / 64'd10);
    localparam logic [DW-1:0] VAL_MAX      = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] VAL_MIN      = {1'b1, {(DW-1){1'b0}}};

    localparam logic [DW-1:0]   RST_MAX_SPEED  = DW'(64'd1 << FB);
    localparam logic [DW-2:0]   RST_MAX_ACCEL  = (DW-1)'(64'd1 << FB);
    localparam logic [DW-2:0]   RST_GAIN       = (DW-1)'(64'd50 << FB);
    localparam logic [DW-1:0]   RST_TERM_SPEED = '0;
    localparam logic [FB:0]     RST_TICK       = (FB+1)'(((64'd1 << FB) + 64'd500) / 64'd1000);

    localparam logic [CW-1:0] MUL_LAST = CW'(6);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_SQRT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [DW-1:0] max_speed;
        logic [DW-2:0] max_accel;
        logic [DW-2:0] position_gain;
        logic [DW-1:0] terminal_speed;
        logic [FB:0]   tick_period;
    } t_cfg;

    // Drop fraction bits of a product and saturate to the positive range.
    function automatic logic [DW-2:0] qsat(input logic [2*DW-1:0] p);
        logic [DW-2:0] r;
        if (|p[2*DW-1:DW-1+FB]) begin
            r = '1;
        end else begin
            r = p[DW-2+FB:FB];
        end
        return r;
    endfunction

endpackage

### rtl/tsp_regs.sv
// Configuration register file behind the APB-style port.
module tsp_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [tsp_pkg::AW-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output tsp_pkg::t_cfg         o_cfg
);
    import tsp_pkg::*;

    t_cfg          r_cfg;
    logic [IW-1:0] idx;
    logic          wr;

    assign idx    = paddr[AW-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed      <= RST_MAX_SPEED;
            r_cfg.max_accel      <= RST_MAX_ACCEL;
            r_cfg.position_gain  <= RST_GAIN;
            r_cfg.terminal_speed <= RST_TERM_SPEED;
            r_cfg.tick_period    <= RST_TICK;
        end else if (wr) begin
            case (idx)
                REG_MAX_SPEED:      r_cfg.max_speed      <= pwdata[DW-1:0];
                REG_MAX_ACCEL:      r_cfg.max_accel      <= pwdata[DW-2:0];
                REG_POSITION_GAIN:  r_cfg.position_gain  <= pwdata[DW-2:0];
                REG_TERMINAL_SPEED: r_cfg.terminal_speed <= pwdata[DW-1:0];
                REG_TICK_PERIOD:    r_cfg.tick_period    <= pwdata[FB:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MAX_SPEED:      prdata = 32'(r_cfg.max_speed);
            REG_MAX_ACCEL:      prdata = 32'(r_cfg.max_accel);
            REG_POSITION_GAIN:  prdata = 32'(r_cfg.position_gain);
            REG_TERMINAL_SPEED: prdata = 32'(r_cfg.terminal_speed);
            REG_TICK_PERIOD:    prdata = 32'(r_cfg.tick_period);
            default:            prdata = '0;
        endcase
    end

endmodule

### rtl/travel_speed_profiler.sv
// Speed profiler top level: one travel request in, one speed reference out.
// A 16-step fraction divide runs first when travel and vmax are positive
// and vmax exceeds |travel|; then the shared multiplier (7) runs, then
// the 33-step restoring square root, one bit per cycle, then the final bounding.
// A new request is taken only in idle, after the previous result has left the final state.
// Reset: synchronous active low; clears the stored previous speed and output valid, loads register defaults.
module travel_speed_profiler (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [tsp_pkg::DW-1:0] i_travel,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [tsp_pkg::DW-1:0] o_speed_ref,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [tsp_pkg::AW-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import tsp_pkg::*;

    t_cfg   cfg;
    t_state r_state, n_state;

    logic [DW-1:0]   r_tmag, r_t0, r_out, r_vref;
    logic [DW-1:0]   r_rem;
    logic            r_tneg, r_t0neg, r_oval;
    logic [CW-1:0]   r_cnt;
    logic [2*DW-1:0] r_prod;
    logic [DW-2:0]   r_x, r_dv, r_gm;
    logic [2*DW+1:0] r_rad;
    logic [DW+1:0]   r_sqrem;
    logic [DW:0]     r_root;

    tsp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // entry decode
    logic [DW-1:0] tmag_in, vtm, t0_neg;
    logic          pos_case, neg_case, vmax_le;
    logic          accept, out_busy;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_busy = r_oval && i_stall;
    assign tmag_in  = i_travel[DW-1] ? (DW'(0) - i_travel) : i_travel;
    assign pos_case = !i_travel[DW-1] && (|i_travel) &&
                      !cfg.max_speed[DW-1] && (|cfg.max_speed);
    assign neg_case = i_travel[DW-1] && cfg.max_speed[DW-1];
    assign vmax_le  = cfg.max_speed <= tmag_in;
    assign vtm      = cfg.terminal_speed[DW-1] ? (DW'(0) - cfg.terminal_speed)
                                               : cfg.terminal_speed;
    assign t0_neg   = (tmag_in > (VAL_MIN >> FB)) ? VAL_MIN : (tmag_in << FB);

    // divider step
    logic [DW:0]   rem2;
    logic          div_ge;
    logic [DW-1:0] q_n;
    assign rem2   = {r_rem, 1'b0};
    assign div_ge = rem2 >= {1'b0, cfg.max_speed};
    assign q_n    = {r_t0[DW-2:0], div_ge};

    // shared multiplier operands
    logic [DW-1:0] mul_a, mul_b;
    always_comb begin
        case (r_cnt)
            CW'(0):  begin mul_a = DW'(cfg.max_accel);     mul_b = r_t0;                  end
            CW'(1):  begin mul_a = r_tmag;                 mul_b = DW'(cfg.max_accel);    end
            CW'(2):  begin mul_a = DW'(cfg.max_accel);     mul_b = DW'(cfg.tick_period);  end
            CW'(3):  begin mul_a = DW'(cfg.position_gain); mul_b = r_tmag;                end
            CW'(4):  begin mul_a = vtm;                    mul_b = vtm;                   end
            CW'(5):  begin mul_a = DW'(r_x);               mul_b = DW'(r_x);              end
            default: begin mul_a = '0;                     mul_b = '0;                    end
        endcase
    end

    // square root step
    logic [DW+3:0] rem_sh, trial;
    logic          sq_ge;
    assign rem_sh = {r_sqrem, r_rad[2*DW+1:2*DW]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign sq_ge  = rem_sh >= trial;

    // final bounding
    logic signed [DW+2:0] lim;
    logic [DW-1:0]        cap, limc;
    logic signed [DW:0]   gv, v1, bnd, v, sum, nlim;
    always_comb begin
        lim = r_t0neg ? $signed((DW+3)'(r_root) + (DW+3)'(r_x))
                      : $signed((DW+3)'(r_root) - (DW+3)'(r_x));
        if (cfg.max_speed == VAL_MIN) begin
            cap = VAL_MAX;
        end else if (cfg.max_speed[DW-1]) begin
            cap = DW'(0) - cfg.max_speed;
        end else begin
            cap = cfg.max_speed;
        end
        limc = (lim > $signed({3'b000, cap})) ? cap : lim[DW-1:0];
        gv   = r_tneg ? -$signed((DW+1)'(r_gm)) : $signed((DW+1)'(r_gm));
        nlim = -$signed((DW+1)'(limc));
        if (!r_tneg) begin
            v1  = (gv < $signed((DW+1)'(limc))) ? gv : $signed((DW+1)'(limc));
            sum = $signed({r_vref[DW-1], r_vref}) + $signed((DW+1)'(r_dv));
        end else begin
            v1  = (gv > nlim) ? gv : nlim;
            sum = $signed({r_vref[DW-1], r_vref}) - $signed((DW+1)'(r_dv));
        end
        if (sum > $signed({1'b0, VAL_MAX})) begin
            bnd = $signed({1'b0, VAL_MAX});
        end else if (sum < $signed({1'b1, VAL_MIN})) begin
            bnd = $signed({1'b1, VAL_MIN});
        end else begin
            bnd = sum;
        end
        if (!r_tneg) begin
            v = (bnd < v1) ? bnd : v1;
        end else begin
            v = (bnd > v1) ? bnd : v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (pos_case && !vmax_le) ? S_DIV : S_MUL;
                end
            end
            S_DIV: begin
                if (r_cnt == CW'(FB - 1)) n_state = S_MUL;
            end
            S_MUL: begin
                if (r_cnt == MUL_LAST) n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_cnt == CW'(DW)) n_state = S_FIN;
            end
            S_FIN: begin
                if (!out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall     = (r_state != S_IDLE);
        o_valid     = r_oval;
        o_speed_ref = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
            r_vref <= '0;
            r_cnt  <= '0;
        end else begin
            if (r_state == S_FIN && !out_busy) begin
                r_oval <= 1'b1;
            end else if (r_oval && !i_stall) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tneg  <= i_travel[DW-1];
                        r_tmag  <= tmag_in;
                        r_cnt   <= '0;
                        r_rad   <= '0;
                        r_t0neg <= neg_case;
                        r_rem   <= tmag_in;
                        if (pos_case) begin
                            r_t0 <= vmax_le ? T0_LOOKAHEAD : '0;
                        end else if (neg_case) begin
                            r_t0 <= t0_neg;
                        end else begin
                            r_t0 <= '0;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? DW'(rem2 - {1'b0, cfg.max_speed}) : rem2[DW-1:0];
                    if (r_cnt == CW'(FB - 1)) begin
                        r_t0  <= (q_n < T0_LOOKAHEAD) ? q_n : T0_LOOKAHEAD;
                        r_cnt <= '0;
                    end else begin
                        r_t0  <= q_n;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_MUL: begin
                    r_prod <= mul_a * mul_b;
                    r_cnt  <= (r_cnt == MUL_LAST) ? '0 : r_cnt + CW'(1);
                    case (r_cnt)
                        CW'(1): r_x   <= qsat(r_prod);
                        CW'(2): r_rad <= r_rad + (2*DW+2)'({r_prod, 1'b0});
                        CW'(3): r_dv  <= qsat(r_prod);
                        CW'(4): r_gm  <= qsat(r_prod);
                        CW'(5): r_rad <= r_rad + (2*DW+2)'(r_prod);
                        CW'(6): begin
                            r_rad   <= r_rad + (2*DW+2)'(r_prod);
                            r_sqrem <= '0;
                            r_root  <= '0;
                        end
                        default: ;
                    endcase
                end
                S_SQRT: begin
                    r_sqrem <= sq_ge ? (DW+2)'(rem_sh - trial) : rem_sh[DW+1:0];
                    r_root  <= {r_root[DW-1:0], sq_ge};
                    r_rad   <= {r_rad[2*DW-1:0], 2'b00};
                    r_cnt   <= (r_cnt == CW'(DW)) ? '0 : r_cnt + CW'(1);
                end
                S_FIN: begin
                    if (!out_busy) begin
                        r_out  <= v[DW-1:0];
                        r_vref <= v[DW-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### rtl/tsp_checker.sv
// Port-level checker for the travel speed profiler, bound to the top level.
`include "travel_speed_profiler_macros.svh"

module tsp_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [tsp_pkg::DW-1:0] o_speed_ref,
    input logic                   pready
);

    `TSP_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && !o_stall)
    `TSP_ASSERT(a_busy_after_req, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall)
    `TSP_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_speed_ref))
    `TSP_ASSERT(a_pready_high, i_clk, i_rst_n, pready)

endmodule

bind travel_speed_profiler tsp_checker u_tsp_checker (.*);

### sim/tb_travel_speed_profiler.sv
// Self-checking testbench of the travel speed profiler: directed table, register extremes, then random requests.
module tb_travel_speed_profiler;
    import tsp_pkg::*;

    localparam int NRAND = 500;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [DW-1:0]        i_travel;
    logic                 o_valid;
    logic                 i_stall;
    logic [DW-1:0]        o_speed_ref;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AW-1:0]        paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    travel_speed_profiler u_dut (.*);

    typedef struct {
        logic [DW-1:0] travel;
        bit            known;
        logic [DW-1:0] speed;
    } t_row;

    t_cfg                 cfg_model;
    logic signed [63:0]   speed_state;
    logic [DW-1:0]        speed_queue[$];
    int                   errors;
    bit                   idle_on;
    bit                   hold_rx;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #60000000;
        $display("travel_speed_profiler regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic logic [127:0] sqrt_floor(input logic [127:0] n);
        logic [127:0] res;
        logic [127:0] cand;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (128'd1 << b);
            if (cand * cand <= n) res = cand;
        end
        return res;
    endfunction

    function automatic logic [63:0] qmul_sat(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = (128'(a) * 128'(b)) >> FB;
        return (p > 128'(VAL_MAX)) ? 64'(VAL_MAX) : p[63:0];
    endfunction

    function automatic logic [DW-1:0] predict_speed(input logic [DW-1:0] trv_bits);
        logic signed [63:0]  trv, vmax, vt, lim, gv, bound, v;
        logic [63:0]         tmag, t0m, x, sq, cap, dv, gm, a, q;
        logic [127:0]        rad;
        bit                  t0neg;
        trv   = 64'($signed(trv_bits));
        vmax  = 64'($signed(cfg_model.max_speed));
        vt    = 64'($signed(cfg_model.terminal_speed));
        a     = 64'(cfg_model.max_accel);
        tmag  = trv < 0 ? -trv : trv;
        t0m   = 0;
        t0neg = 0;
        if (trv > 0 && vmax > 0) begin
            if (vmax <= tmag) begin
                t0m = 64'(T0_LOOKAHEAD);
            end else begin
                q = (tmag << FB) / vmax;
                t0m = q < 64'(T0_LOOKAHEAD) ? q : 64'(T0_LOOKAHEAD);
            end
        end else if (trv < 0 && vmax < 0) begin
            t0neg = 1;
            t0m = tmag > (64'd1 << (DW - 1 - FB)) ? (64'd1 << (DW - 1)) : (tmag << FB);
        end
        x   = qmul_sat(a, t0m);
        rad = 128'(x) * x + 2 * (128'(tmag) * a)
            + 128'(vt < 0 ? -vt : vt) * 128'(vt < 0 ? -vt : vt);
        sq  = 64'(sqrt_floor(rad));
        lim = t0neg ? $signed(sq + x) : $signed(sq) - $signed(x);
        cap = vmax < 0 ? -vmax : vmax;
        if (cap > 64'(VAL_MAX)) cap = 64'(VAL_MAX);
        if (lim > $signed(cap)) lim = $signed(cap);
        dv = qmul_sat(a, 64'(cfg_model.tick_period));
        gm = qmul_sat(64'(cfg_model.position_gain), tmag);
        gv = trv < 0 ? -$signed(gm) : $signed(gm);
        if (trv >= 0) begin
            v = gv < lim ? gv : lim;
            bound = speed_state + $signed(dv);
            if (bound > $signed(64'(VAL_MAX))) bound = 64'(VAL_MAX);
            if (bound < v) v = bound;
        end else begin
            v = gv > -lim ? gv : -lim;
            bound = speed_state - $signed(dv);
            if (bound < $signed({{32{1'b1}}, VAL_MIN})) bound = $signed({{32{1'b1}}, VAL_MIN});
            if (bound > v) v = bound;
        end
        speed_state = v;
        return v[DW-1:0];
    endfunction

    task automatic write_reg(input logic [IW-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_MAX_SPEED:      cfg_model.max_speed      = val;
            REG_MAX_ACCEL:      cfg_model.max_accel      = val[DW-2:0];
            REG_POSITION_GAIN:  cfg_model.position_gain  = val[DW-2:0];
            REG_TERMINAL_SPEED: cfg_model.terminal_speed = val;
            REG_TICK_PERIOD:    cfg_model.tick_period    = val[FB:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_travel(input logic [DW-1:0] trv, input bit known, input logic [DW-1:0] spd);
        logic [DW-1:0] pred;
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_travel <= trv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = predict_speed(trv);
        if (known && pred !== spd) report_mismatch($sformatf("table row %h", trv));
        speed_queue.push_back(pred);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (speed_queue.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    function automatic logic [DW-1:0] rand_travel;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return DW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return DW'($signed($urandom_range(0, 1 << 14)) - (1 << 13));
            3: return $urandom_range(0, 1) ? VAL_MAX - $urandom_range(0, 3) : VAL_MIN + $urandom_range(0, 3);
            default: return DW'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (speed_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected speed %h", o_speed_ref));
            end else begin
                if (o_speed_ref !== speed_queue[0])
                    report_mismatch($sformatf("speed_ref %h, want %h", o_speed_ref, speed_queue[0]));
                void'(speed_queue.pop_front());
            end
        end
    end

    initial begin
        int burst;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                i_stall <= 1'b0;
                hold_rx = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 4);
                i_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    t_row table_rows[] = '{
        '{32'h0000_0000, 1'b1, 32'h0000_0000},
        '{32'h7FFF_FFFF, 1'b1, 32'h0000_0042},
        '{32'h8000_0000, 1'b1, 32'h0000_0000},
        '{32'h0001_0000, 1'b0, 32'h0},
        '{32'hFFFF_0000, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 32'h0},
        '{32'h0000_0800, 1'b0, 32'h0},
        '{32'h0010_0000, 1'b0, 32'h0}
    };

    initial begin
        logic [31:0] cfgv[5];
        errors   = 0;
        idle_on  = 1'b1;
        hold_rx  = 1'b0;
        i_valid  = 1'b0;
        i_travel = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_model = '{RST_MAX_SPEED, RST_MAX_ACCEL, RST_GAIN, RST_TERM_SPEED, RST_TICK};
        speed_state = 0;
        i_rst_n  = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n  = 1'b1;

        foreach (table_rows[k])
            send_travel(table_rows[k].travel, table_rows[k].known, table_rows[k].speed);
        drain();

        // extremes of every register
        write_reg(REG_MAX_SPEED, 32'h8000_0000);
        write_reg(REG_MAX_ACCEL, 32'h7FFF_FFFF);
        write_reg(REG_POSITION_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_TERMINAL_SPEED, 32'h8000_0000);
        write_reg(REG_TICK_PERIOD, 32'h0001_0000);
        foreach (table_rows[k]) send_travel(table_rows[k].travel, 1'b0, '0);
        drain();
        write_reg(REG_MAX_SPEED, 32'hFFFF_FFFF);
        write_reg(REG_MAX_ACCEL, 32'h0);
        write_reg(REG_POSITION_GAIN, 32'h0);
        write_reg(REG_TERMINAL_SPEED, 32'h7FFF_FFFF);
        write_reg(REG_TICK_PERIOD, 32'h1);
        foreach (table_rows[k]) send_travel(table_rows[k].travel, 1'b0, '0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            cfgv[0] = $urandom_range(0, 1) ? $urandom : DW'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            cfgv[1] = $urandom_range(0, 1) ? $urandom_range(0, 1 << 20) : $urandom;
            cfgv[2] = $urandom_range(0, 1) ? $urandom_range(0, 1 << 23) : $urandom;
            cfgv[3] = $urandom_range(0, 1) ? DW'($signed($urandom_range(0, 1 << 18)) - (1 << 17)) : $urandom;
            cfgv[4] = $urandom_range(0, 1) ? $urandom_range(1, 2000) : $urandom_range(0, 65536);
            write_reg(REG_MAX_SPEED, cfgv[0]);
            write_reg(REG_MAX_ACCEL, cfgv[1]);
            write_reg(REG_POSITION_GAIN, cfgv[2]);
            write_reg(REG_TERMINAL_SPEED, cfgv[3]);
            write_reg(REG_TICK_PERIOD, cfgv[4]);
            if (ph == 2) hold_rx = 1'b1;
            if (ph == 5) idle_on = 1'b0;
            for (int n = 0; n < NRAND / 6; n++) send_travel(rand_travel(), 1'b0, '0);
            drain();
        end

        if (errors == 0) begin
            $display("travel_speed_profiler regression: pass");
        end else begin
            $display("travel_speed_profiler regression: fail");
        end
        $finish;
    end
endmodule
